// File: rtl/mqtt_packet_receive_parser_defines.svh
// Assertion macros shared by the checker of the MQTT receive parser.
`ifndef MQTT_PACKET_RECEIVE_PARSER_DEFINES_SVH
`define MQTT_PACKET_RECEIVE_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define MQPR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mqpr check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define MQPR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mqpr check failed");

`endif

// File: rtl/mqpr_pkg.sv
package mqpr_pkg;

    localparam int LEN_W = 28;

    localparam logic [3:0] TYPE_CONNACK  = 4'd2;
    localparam logic [3:0] TYPE_PUBLISH  = 4'd3;
    localparam logic [3:0] TYPE_PUBACK   = 4'd4;
    localparam logic [3:0] TYPE_PUBREC   = 4'd5;
    localparam logic [3:0] TYPE_PUBREL   = 4'd6;
    localparam logic [3:0] TYPE_PUBCOMP  = 4'd7;
    localparam logic [3:0] TYPE_SUBACK   = 4'd9;
    localparam logic [3:0] TYPE_UNSUBACK = 4'd11;

    localparam logic [1:0] LAST_LEN_BYTE = 2'd3;

    typedef enum logic [3:0] {
        PH_CTRL,
        PH_LEN,
        PH_TLEN_HI,
        PH_TLEN_LO,
        PH_TOPIC,
        PH_ID_HI,
        PH_ID_LO,
        PH_PAYLOAD,
        PH_ACK0,
        PH_ACK1,
        PH_ACK2,
        PH_SKIP_REP,
        PH_SKIP_QUIET
    } t_phase;

    typedef enum logic [2:0] {
        KIND_TOPIC,
        KIND_PAYLOAD,
        KIND_PUBEND,
        KIND_CONTROL,
        KIND_MALFORM
    } t_kind;

    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [7:0]  data;
        logic [3:0]  ptype;
        logic [3:0]  hflags;
        logic [15:0] id;
        logic [7:0]  code;
        logic [7:0]  ack;
        logic        last;
    } t_result;

endpackage

// File: rtl/mqpr_parse_core.sv
module mqpr_parse_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  logic [7:0]       i_byte,
    output mqpr_pkg::t_result o_res
);
    import mqpr_pkg::*;

    t_phase           r_phase, n_phase;
    logic [7:0]       r_header, n_header;
    logic [LEN_W-1:0] r_left, n_left;
    logic [1:0]       r_lcnt, n_lcnt;
    logic [15:0]      r_topic, n_topic;
    logic [15:0]      r_id, n_id;
    logic [7:0]       r_code, n_code;
    logic [7:0]       r_flags, n_flags;

    logic             emit;
    t_kind            kind;
    logic [7:0]       data;
    logic             last;
    logic             qos_nz;
    logic             at_end;
    logic [LEN_W-1:0] len_grp;
    logic [LEN_W-1:0] len_sum;
    logic [2:0]       need;
    logic [15:0]      topic_full;
    logic             topic_bad;

    function automatic logic [2:0] header_need(logic [3:0] t, logic q);
        logic [2:0] n;
        case (t)
            TYPE_PUBLISH:  n = q ? 3'd4 : 3'd2;
            TYPE_CONNACK, TYPE_PUBACK, TYPE_PUBREC, TYPE_PUBREL,
            TYPE_PUBCOMP, TYPE_UNSUBACK: n = 3'd2;
            TYPE_SUBACK:   n = 3'd3;
            default:       n = 3'd0;
        endcase
        return n;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CTRL;
        end else if (i_go) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_header <= n_header;
            r_left   <= n_left;
            r_lcnt   <= n_lcnt;
            r_topic  <= n_topic;
            r_id     <= n_id;
            r_code   <= n_code;
            r_flags  <= n_flags;
        end
    end

    always_comb begin
        case (r_lcnt)
            2'd0:    len_grp = {21'd0, i_byte[6:0]};
            2'd1:    len_grp = {14'd0, i_byte[6:0], 7'd0};
            2'd2:    len_grp = {7'd0, i_byte[6:0], 14'd0};
            default: len_grp = {i_byte[6:0], 21'd0};
        endcase
    end

    assign qos_nz     = |r_header[2:1];
    assign at_end     = (r_left == LEN_W'(1));
    assign len_sum    = r_left | len_grp;
    assign need       = header_need(r_header[7:4], qos_nz);
    assign topic_full = {r_topic[15:8], i_byte};
    assign topic_bad  = (LEN_W'(topic_full) + (qos_nz ? LEN_W'(2) : LEN_W'(0))) >= r_left;

    always_comb begin
        n_phase  = r_phase;
        n_header = r_header;
        n_left   = r_left;
        n_lcnt   = r_lcnt;
        n_topic  = r_topic;
        n_id     = r_id;
        n_code   = r_code;
        n_flags  = r_flags;
        emit     = 1'b0;
        kind     = KIND_CONTROL;
        data     = 8'd0;
        last     = 1'b0;

        if (r_phase == PH_CTRL) begin
            n_header = i_byte;
            n_left   = '0;
            n_lcnt   = 2'd0;
            n_topic  = 16'd0;
            n_id     = 16'd0;
            n_code   = 8'd0;
            n_flags  = 8'd0;
            n_phase  = PH_LEN;
        end else if (r_phase == PH_LEN) begin
            n_left = len_sum;
            n_lcnt = r_lcnt + 2'd1;
            if (i_byte[7]) begin
                if (r_lcnt == LAST_LEN_BYTE) begin
                    n_left  = '0;
                    n_phase = PH_CTRL;
                    emit    = 1'b1;
                    kind    = KIND_MALFORM;
                    last    = 1'b1;
                end
            end else if (len_sum < LEN_W'(need)) begin
                n_phase = (len_sum != '0) ? PH_SKIP_QUIET : PH_CTRL;
                emit    = 1'b1;
                kind    = KIND_MALFORM;
                last    = 1'b1;
            end else if (r_header[7:4] == TYPE_PUBLISH) begin
                n_phase = PH_TLEN_HI;
            end else if (need != 3'd0) begin
                n_phase = PH_ACK0;
            end else if (len_sum == '0) begin
                n_phase = PH_CTRL;
                emit    = 1'b1;
                kind    = KIND_CONTROL;
                last    = 1'b1;
            end else begin
                n_phase = PH_SKIP_REP;
            end
        end else if (r_left == '0) begin
            n_phase = PH_CTRL;
        end else begin
            n_left = r_left - LEN_W'(1);
            case (r_phase)
                PH_TLEN_HI: begin
                    n_topic = {i_byte, 8'd0};
                    n_phase = PH_TLEN_LO;
                end
                PH_TLEN_LO: begin
                    n_topic = topic_full;
                    if (topic_bad) begin
                        n_phase = at_end ? PH_CTRL : PH_SKIP_QUIET;
                        emit    = 1'b1;
                        kind    = KIND_MALFORM;
                        last    = 1'b1;
                    end else if (topic_full != 16'd0) begin
                        n_phase = PH_TOPIC;
                    end else if (qos_nz) begin
                        n_phase = PH_ID_HI;
                    end else if (!at_end) begin
                        n_phase = PH_PAYLOAD;
                    end else begin
                        n_phase = PH_CTRL;
                        emit    = 1'b1;
                        kind    = KIND_PUBEND;
                        last    = 1'b1;
                    end
                end
                PH_TOPIC: begin
                    n_topic = r_topic - 16'd1;
                    if (at_end) begin
                        n_phase = PH_CTRL;
                    end else if (r_topic == 16'd1) begin
                        n_phase = qos_nz ? PH_ID_HI : PH_PAYLOAD;
                    end
                    emit = 1'b1;
                    kind = KIND_TOPIC;
                    data = i_byte;
                    last = at_end;
                end
                PH_ID_HI: begin
                    n_id    = {i_byte, 8'd0};
                    n_phase = PH_ID_LO;
                end
                PH_ID_LO: begin
                    n_id = {r_id[15:8], i_byte};
                    if (at_end) begin
                        n_phase = PH_CTRL;
                        emit    = 1'b1;
                        kind    = KIND_PUBEND;
                        last    = 1'b1;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if (at_end) begin
                        n_phase = PH_CTRL;
                    end
                    emit = 1'b1;
                    kind = KIND_PAYLOAD;
                    data = i_byte;
                    last = at_end;
                end
                PH_ACK0, PH_ACK1, PH_ACK2, PH_SKIP_REP: begin
                    if (r_phase == PH_ACK0) begin
                        if (r_header[7:4] == TYPE_CONNACK) begin
                            n_flags = i_byte;
                        end else begin
                            n_id = {i_byte, 8'd0};
                        end
                    end else if (r_phase == PH_ACK1) begin
                        if (r_header[7:4] == TYPE_CONNACK) begin
                            n_code = i_byte;
                        end else begin
                            n_id = {r_id[15:8], i_byte};
                        end
                    end else if (r_phase == PH_ACK2) begin
                        n_code = i_byte;
                    end
                    if (at_end) begin
                        n_phase = PH_CTRL;
                        emit    = 1'b1;
                        kind    = KIND_CONTROL;
                        last    = 1'b1;
                    end else if (r_phase == PH_ACK0) begin
                        n_phase = PH_ACK1;
                    end else if (r_phase == PH_ACK1 && r_header[7:4] == TYPE_SUBACK) begin
                        n_phase = PH_ACK2;
                    end else begin
                        n_phase = PH_SKIP_REP;
                    end
                end
                default: begin
                    n_phase = at_end ? PH_CTRL : PH_SKIP_QUIET;
                end
            endcase
        end
    end

    always_comb begin
        o_res.valid  = i_go && emit;
        o_res.kind   = kind;
        o_res.data   = data;
        o_res.ptype  = n_header[7:4];
        o_res.hflags = n_header[3:0];
        o_res.id     = (kind == KIND_MALFORM) ? 16'd0 : n_id;
        o_res.code   = (kind == KIND_CONTROL) ? n_code : 8'd0;
        o_res.ack    = (kind == KIND_CONTROL) ? n_flags : 8'd0;
        o_res.last   = last;
    end

endmodule

// File: rtl/mqpr_out_reg.sv
module mqpr_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mqpr_pkg::t_result i_res,
    input  logic              i_stall,
    output logic              o_free,
    output mqpr_pkg::t_result o_res
);
    import mqpr_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_res.valid) begin
            r_res <= i_res;
        end
    end

    always_comb begin
        o_res       = r_res;
        o_res.valid = r_valid;
    end

endmodule

// File: rtl/mqtt_packet_receive_parser.sv
// MQTT control packet receive parser, one stream byte per transaction.
// A byte is held in the input register; its event is then held in the event register.
// Throughput: one byte per cycle unless i_ev_stall holds an event; the input
// register and the event register let a new byte in while an event waits downstream.
// Reset is synchronous and active low; it empties both registers and returns
// the parser to waiting for a control byte.
module mqtt_packet_receive_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_ev_valid,
    input  logic        i_ev_stall,
    output logic [2:0]  o_event_kind,
    output logic [7:0]  o_data_byte,
    output logic [3:0]  o_packet_type,
    output logic [3:0]  o_header_flags,
    output logic [15:0] o_packet_id,
    output logic [7:0]  o_return_code,
    output logic [7:0]  o_ack_flags,
    output logic        o_last
);
    import mqpr_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       out_free;
    logic       go;
    logic       rx_take;
    t_result    core_res;
    t_result    ev_res;

    assign go         = r_in_valid && out_free;
    assign o_rx_stall = r_in_valid && !out_free;
    assign rx_take    = i_rx_valid && !o_rx_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (rx_take) begin
            r_in_valid <= 1'b1;
        end else if (go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_take) begin
            r_in_byte <= i_rx_byte;
        end
    end

    mqpr_parse_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_byte  (r_in_byte),
        .o_res   (core_res)
    );

    mqpr_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (core_res),
        .i_stall (i_ev_stall),
        .o_free  (out_free),
        .o_res   (ev_res)
    );

    assign o_ev_valid     = ev_res.valid;
    assign o_event_kind   = ev_res.kind;
    assign o_data_byte    = ev_res.data;
    assign o_packet_type  = ev_res.ptype;
    assign o_header_flags = ev_res.hflags;
    assign o_packet_id    = ev_res.id;
    assign o_return_code  = ev_res.code;
    assign o_ack_flags    = ev_res.ack;
    assign o_last         = ev_res.last;

endmodule

// File: rtl/mqpr_checker.sv
`include "mqtt_packet_receive_parser_defines.svh"

module mqpr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_rx_stall,
    input logic        o_ev_valid,
    input logic        i_ev_stall,
    input logic [2:0]  o_event_kind,
    input logic [7:0]  o_data_byte,
    input logic [15:0] o_packet_id,
    input logic [7:0]  o_return_code,
    input logic [7:0]  o_ack_flags,
    input logic        o_last
);
    import mqpr_pkg::*;

    `MQPR_ASSERT_NEXT(a_ev_hold, o_ev_valid && i_ev_stall, o_ev_valid && $stable(o_event_kind) && $stable(o_data_byte) && $stable(o_packet_id) && $stable(o_last))
    `MQPR_ASSERT_SAME(a_kind_range, o_ev_valid, o_event_kind <= KIND_MALFORM)
    `MQPR_ASSERT_SAME(a_malform_clean, o_ev_valid && o_event_kind == KIND_MALFORM, o_last && o_packet_id == 16'd0 && o_return_code == 8'd0 && o_ack_flags == 8'd0 && o_data_byte == 8'd0)
    `MQPR_ASSERT_SAME(a_end_kinds, o_ev_valid && (o_event_kind == KIND_PUBEND || o_event_kind == KIND_CONTROL), o_last && o_data_byte == 8'd0 && (o_event_kind == KIND_CONTROL || (o_return_code == 8'd0 && o_ack_flags == 8'd0)))
    `MQPR_ASSERT_SAME(a_stall_cause, o_rx_stall, o_ev_valid && i_ev_stall)

endmodule

bind mqtt_packet_receive_parser mqpr_checker u_mqpr_checker (.*);
